// ----- rtl/ppi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg: shared constants for the planar pose integrator
// fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = 4;

  localparam logic signed [19:0] PiQ     = 20'sd205887;
  localparam logic signed [20:0] TwoPiQ  = 21'sd411774;
  localparam logic signed [19:0] HalfPiQ = 20'sd102943;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;

  function automatic logic [15:0] atan_q(input logic [StepW-1:0] i);
    logic [15:0] r;
    case (i)
      4'd0:    r = 16'd51472;
      4'd1:    r = 16'd30386;
      4'd2:    r = 16'd16055;
      4'd3:    r = 16'd8150;
      4'd4:    r = 16'd4091;
      4'd5:    r = 16'd2047;
      4'd6:    r = 16'd1024;
      4'd7:    r = 16'd512;
      4'd8:    r = 16'd256;
      4'd9:    r = 16'd128;
      4'd10:   r = 16'd64;
      4'd11:   r = 16'd32;
      4'd12:   r = 16'd16;
      4'd13:   r = 16'd8;
      4'd14:   r = 16'd4;
      default: r = 16'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ppi_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_cordic: iterative rotation-mode cordic
// one micro-rotation per cycle, cos and sin of a q3.16 angle in q1.30
// ----------------------------------------------------------------------------
module ppi_cordic (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [19:0]  angle,
  output logic                     done,
  output logic signed [31:0]       cos_q,
  output logic signed [31:0]       sin_q
);

  logic signed [31:0] x, y;
  logic signed [20:0] z;
  logic [ppi_pkg::StepW-1:0] step;
  logic busy, neg;
  logic signed [20:0] z0;
  logic fold;
  logic signed [31:0] xs, ys;
  logic signed [20:0] at;

  always_comb begin
    fold = 1'b0;
    z0 = 21'(angle);
    if (angle > ppi_pkg::HalfPiQ) begin
      z0 = 21'(angle) - 21'(ppi_pkg::PiQ);
      fold = 1'b1;
    end else if (angle < -ppi_pkg::HalfPiQ) begin
      z0 = 21'(angle) + 21'(ppi_pkg::PiQ);
      fold = 1'b1;
    end
    xs = x >>> step;
    ys = y >>> step;
    at = 21'(signed'({1'b0, ppi_pkg::atan_q(step)}));
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      x <= ppi_pkg::CordicGain;
      y <= '0;
      z <= z0;
      neg <= fold;
    end else if (busy) begin
      if (!z[20]) begin
        x <= x - ys; y <= y + xs; z <= z - at;
      end else begin
        x <= x + ys; y <= y - xs; z <= z + at;
      end
      step <= step + 1'b1;
      if (step == ppi_pkg::StepW'(ppi_pkg::CordicSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign cos_q = neg ? -x : x;
  assign sin_q = neg ? -y : y;

endmodule
`default_nettype wire

// ----- rtl/planar_pose_integrator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_pose_integrator: planar dead-reckoning pose update
// integrates a body twist over a time step into a world pose
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one twist item: forward speed, lateral speed, yaw rate
//   (signed q7.16) and a q0.16 time step. m_axis returns one pose item per
//   input: x, y (q15.16, wrapping) and heading (q2.16, in (-pi, pi]).
//   cos/sin of the stored heading come from a 16-step iterative cordic,
//   then one shared 32x32 multiplier does the seven products one per cycle.
//   an item passes from accept to result valid through 16 cordic steps,
//   a hand-off to the multiply state, seven multiplies and a sum state.
//   with m_axis_tready high the result leaves in the cycle it appears and
//   the next item is accepted in the cycle after; items do not overlap.
//   reset clears the pose to zero and empties the result register; no item
//   is accepted while reset is high.
//   when the receiver stalls, the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module planar_pose_integrator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // forward_speed[23:0], lateral_speed[47:24], yaw_rate[71:48], time_step[87:72]
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // position_x[31:0], position_y[63:32], heading[82:64], zero[87:83]
  output logic [87:0]      m_axis_tdata
);

  typedef enum logic [2:0] {IDLE, TRIG, MUL, SUM, OUT} state_t;
  state_t state;

  logic signed [23:0] vx, vy, wz;
  logic [15:0] dt;
  logic signed [31:0] px, py;
  logic signed [19:0] ph;
  logic [2:0] mstep;

  // shared multiplier operands
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] acc;    // accumulated world velocity product
  logic signed [63:0] wx, wy;
  logic signed [63:0] dx, dy, dh;
  logic signed [47:0] wxr, wyr;

  logic cstart, cdone;
  logic signed [31:0] cq, sq;

  ppi_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(ph),
    .done(cdone), .cos_q(cq), .sin_q(sq)
  );

  assign s_axis_tready = (state == IDLE) && !rst;
  assign cstart = s_axis_tvalid && s_axis_tready;

  // rounded world velocities, q.16
  assign wxr = 48'((wx + 64'sd536870912) >>> 30);
  assign wyr = 48'((wy + 64'sd536870912) >>> 30);

  // operand selection for each multiply step
  always_comb begin
    ma = '0;
    mb = '0;
    case (mstep)
      3'd0: begin ma = 32'(vx); mb = cq; end
      3'd1: begin ma = 32'(vy); mb = sq; end
      3'd2: begin ma = 32'(vx); mb = sq; end
      3'd3: begin ma = 32'(vy); mb = cq; end
      3'd4: begin ma = 32'(wz); mb = signed'({16'd0, dt}); end
      3'd5: begin ma = 32'(wxr); mb = signed'({16'd0, dt}); end
      3'd6: begin ma = 32'(wyr); mb = signed'({16'd0, dt}); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  // heading update, saturate then single wrap, and rounded position steps
  logic signed [63:0] dhr;
  logic signed [20:0] dhs, hsum, hw;
  logic signed [63:0] dxr, dyr;
  always_comb begin
    dhr = (dh + 64'sd32768) >>> 16;
    if (dhr > 64'(ppi_pkg::PiQ)) dhs = 21'(ppi_pkg::PiQ);
    else if (dhr < -64'(ppi_pkg::PiQ)) dhs = -21'(ppi_pkg::PiQ);
    else dhs = 21'(dhr);
    hsum = 21'(ph) + dhs;
    if (hsum > 21'(ppi_pkg::PiQ)) hw = hsum - ppi_pkg::TwoPiQ;
    else if (hsum <= -21'(ppi_pkg::PiQ)) hw = hsum + ppi_pkg::TwoPiQ;
    else hw = hsum;
    dxr = (dx + 64'sd32768) >>> 16;
    dyr = (dy + 64'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      m_axis_tvalid <= 1'b0;
      px <= '0;
      py <= '0;
      ph <= '0;
      mstep <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (cstart) begin
            vx <= s_axis_tdata[23:0];
            vy <= s_axis_tdata[47:24];
            wz <= s_axis_tdata[71:48];
            dt <= s_axis_tdata[87:72];
            state <= TRIG;
          end
        end
        TRIG: begin
          if (cdone) begin
            mstep <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          // products: vx*c, vy*s, vx*s, vy*c, wz*dt, wx*dt, wy*dt
          mstep <= mstep + 1'b1;
          case (mstep)
            3'd0: acc <= prod;
            3'd1: wx <= acc - prod;
            3'd2: acc <= prod;
            3'd3: wy <= acc + prod;
            3'd4: dh <= prod;
            3'd5: dx <= prod;
            default: begin
              dy <= prod;
              state <= SUM;
            end
          endcase
        end
        SUM: begin
          px <= px + 32'(dxr);
          py <= py + 32'(dyr);
          ph <= 20'(hw);
          m_axis_tdata <= {5'd0, 19'(hw), py + 32'(dyr), px + 32'(dxr)};
          m_axis_tvalid <= 1'b1;
          state <= OUT;
        end
        OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ppi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_checker: port-level checks for the pose integrator
// watches handshakes and result ordering on the top-level ports
// ----------------------------------------------------------------------------
module ppi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata
);

  // stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no input accepted while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");

  // an accepted item never produces a result the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  // heading is within (-pi, pi]
  a_head: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[82:64]) <= 19'sd205887)
      && ($signed(m_axis_tdata[82:64]) > -19'sd205887))
    else $error("heading out of range");

endmodule

bind planar_pose_integrator ppi_checker u_ppi_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- tb/pose_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_checker: pose prediction and comparison for the planar pose integrator
// watches both streams, predicts each pose and compares it field by field
// ----------------------------------------------------------------------------
module pose_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [87:0] m_axis_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [18:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  pose_t         pose_fifo[$];
  logic   [31:0] est_x, est_y;
  longint        est_heading;

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // cordic rotation of the stored heading, cos and sin in q1.30
  task automatic heading_trig(input longint h, output longint c,
                              output longint sn);
    longint x, y, z, xs, ys;
    bit     flip;
    x = ppi_pkg::CordicGain;
    y = 0;
    z = h;
    flip = 0;
    if (z > ppi_pkg::HalfPiQ) begin
      z -= ppi_pkg::PiQ;
      flip = 1;
    end else if (z < -ppi_pkg::HalfPiQ) begin
      z += ppi_pkg::PiQ;
      flip = 1;
    end
    for (int i = 0; i < ppi_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ppi_pkg::atan_q(i[ppi_pkg::StepW-1:0]));
      end else begin
        x += ys; y -= xs; z += longint'(ppi_pkg::atan_q(i[ppi_pkg::StepW-1:0]));
      end
    end
    c = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  task automatic integrate_twist(input logic [87:0] d);
    longint vx, vy, wz, dt, c, sn, wx, wy, dh;
    pose_t  p;
    vx = longint'($signed(d[23:0]));
    vy = longint'($signed(d[47:24]));
    wz = longint'($signed(d[71:48]));
    dt = longint'(d[87:72]);
    heading_trig(est_heading, c, sn);
    wx = rshift_round(vx * c - vy * sn, 30);
    wy = rshift_round(vx * sn + vy * c, 30);
    est_x += 32'(rshift_round(wx * dt, 16));
    est_y += 32'(rshift_round(wy * dt, 16));
    dh = rshift_round(wz * dt, 16);
    if (dh > ppi_pkg::PiQ) dh = ppi_pkg::PiQ;
    if (dh < -ppi_pkg::PiQ) dh = -ppi_pkg::PiQ;
    est_heading += dh;
    if (est_heading > ppi_pkg::PiQ) est_heading -= ppi_pkg::TwoPiQ;
    else if (est_heading <= -ppi_pkg::PiQ) est_heading += ppi_pkg::TwoPiQ;
    p.pos_x = est_x;
    p.pos_y = est_y;
    p.heading = 19'(est_heading);
    pose_fifo.push_back(p);
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  // position accumulators are updated blocking inside the task
  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      est_x = 0;
      est_y = 0;
      est_heading = 0;
      pose_fifo.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pose_fifo.size() == 0) begin
          report("unexpected item", m_axis_tdata[31:0], 0);
        end else begin
          e = pose_fifo.pop_front();
          if (m_axis_tdata[31:0] !== e.pos_x)
            report("position_x", m_axis_tdata[31:0], e.pos_x);
          if (m_axis_tdata[63:32] !== e.pos_y)
            report("position_y", m_axis_tdata[63:32], e.pos_y);
          if (m_axis_tdata[82:64] !== e.heading)
            report("heading", 32'(m_axis_tdata[82:64]), 32'(e.heading));
        end
      end
      if (s_axis_tvalid && s_axis_tready) integrate_twist(s_axis_tdata);
    end
    pending = pose_fifo.size();
  end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the planar pose integrator
// directed extremes then random twists with idle bursts on both streams
// ----------------------------------------------------------------------------
module testbench;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // forward_speed[23:0], lateral_speed[47:24], yaw_rate[71:48], time_step[87:72]
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // position_x[31:0], position_y[63:32], heading[82:64], zero[87:83]
  logic [87:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          quiet_cycles;
  bit          calm;       // last part of the run: no idling

  localparam int ItemCount = 1000;
  localparam int IdleLimit = 2000;

  planar_pose_integrator uut (.*);

  pose_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: stalls in random bursts, none in the calm tail
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1;
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one twist item, holding valid until accepted
  task automatic send_twist(input logic [23:0] vx, input logic [23:0] vy,
                            input logic [23:0] wz, input logic [15:0] dt);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {dt, wz, vy, vx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] rand_speed();
    case ($urandom_range(0, 4))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2:       return 24'($signed($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dt;
    quiet_cycles  = 0;
    calm          = 0;
    rst           = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed: zero step, extremes, saturating yaw and both heading wraps
    send_twist(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'h0000);
    send_twist(24'h7fffff, 24'h800000, 24'h7fffff, 16'hffff);
    send_twist(24'h800000, 24'h7fffff, 24'h800000, 16'hffff);
    send_twist(24'h010000, 24'h000000, 24'h020000, 16'h8000);
    send_twist(24'h010000, 24'h010000, 24'h020000, 16'h8000);
    send_twist(24'h800000, 24'h800000, 24'h7fffff, 16'hffff);
    send_twist(24'h000000, 24'h000000, 24'h800000, 16'h0001);
    send_twist(24'hffffff, 24'h000001, 24'hffffff, 16'hffff);
    for (int i = 0; i < 8; i++)
      send_twist(24'h7fffff, 24'h7fffff, 24'h030000, 16'hffff);
    for (int i = 0; i < 6; i++)
      send_twist(24'h800000, 24'h000000, 24'hfd0000, 16'hffff);
    // let everything drain once before the random part
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < ItemCount; i++) begin
      if (i == ItemCount - 150) calm = 1;
      case ($urandom_range(0, 3))
        0:       dt = 16'($urandom);
        1:       dt = 16'($urandom_range(0, 255));
        2:       dt = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        default: dt = 16'($urandom_range(0, 4095));
      endcase
      send_twist(rand_speed(), rand_speed(), rand_speed(), dt);
    end
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
